/* hw/rtl/mcs_pkg.sv */
// Shared types and constants for the 16-bit to 8-bit contrast stretch block.
`timescale 1ns / 1ps

package mcs_pkg;

  localparam int PixW  = 16;
  localparam int GrayW = 8;
  localparam int StepW = $clog2(GrayW);

  localparam logic [PixW-1:0]  PIX_MAX   = '1;
  localparam logic [PixW-1:0]  PIX_ZERO  = '0;
  localparam logic [GrayW-1:0] GRAY_FULL = 8'd255;
  localparam logic [GrayW-1:0] GRAY_ZERO = 8'd0;

  localparam logic REQ_MEASURE = 1'b0;
  localparam logic REQ_MAP     = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV,
    ST_DONE
  } mcs_state_t;

  // Update strobe for the min/max tracker
  typedef struct packed {
    logic en;
    logic restart;
  } mm_upd_t;

  // Status of the bit-serial divider
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

/* hw/rtl/mcs_minmax.sv */
// Running minimum and maximum of nonzero measure-pass samples.
`timescale 1ns / 1ps

module mcs_minmax (
  input  logic                     clk,
  input  logic                     rst_n,
  input  mcs_pkg::mm_upd_t         upd,
  input  logic [mcs_pkg::PixW-1:0] pixel,
  output logic [mcs_pkg::PixW-1:0] min_seen,
  output logic [mcs_pkg::PixW-1:0] max_seen
);
  import mcs_pkg::*;

  logic [PixW-1:0] min_r, min_nxt;
  logic [PixW-1:0] max_r, max_nxt;
  logic [PixW-1:0] min_base, max_base;

  // Restart on frame start, then fold in a nonzero sample
  always_comb begin
    min_base = upd.restart ? PIX_MAX : min_r;
    max_base = upd.restart ? PIX_ZERO : max_r;
    min_nxt  = min_r;
    max_nxt  = max_r;
    if (upd.en) begin
      min_nxt = min_base;
      max_nxt = max_base;
      if (pixel != PIX_ZERO) begin
        if (pixel < min_base) min_nxt = pixel;
        if (pixel > max_base) max_nxt = pixel;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r <= PIX_MAX;
      max_r <= PIX_ZERO;
    end else begin
      min_r <= min_nxt;
      max_r <= max_nxt;
    end
  end

  assign min_seen = min_r;
  assign max_seen = max_r;

`ifndef SYNTHESIS
  a_nonzero_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (upd.en && pixel != PIX_ZERO) |=> (min_r <= $past(pixel) && max_r >= $past(pixel)))
    else $error("min/max does not bracket the last measured sample");
  a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (upd.en && upd.restart && pixel == PIX_ZERO) |=> (min_r == PIX_MAX && max_r == PIX_ZERO))
    else $error("frame restart with invalid sample left stale min/max");
  a_hold_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !upd.en |=> ($stable(min_r) && $stable(max_r)))
    else $error("min/max changed without an update");
`endif

endmodule

/* hw/rtl/mcs_div.sv */
// Bit-serial restoring divider: floor(d * 255 / span), one quotient bit per cycle.
`timescale 1ns / 1ps

module mcs_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [mcs_pkg::PixW-1:0]  offset,
  input  logic [mcs_pkg::PixW-1:0]  span,
  output mcs_pkg::div_stat_t        stat,
  output logic [mcs_pkg::GrayW-1:0] quot
);
  import mcs_pkg::*;

  localparam int NumW = PixW + GrayW;
  localparam logic [StepW-1:0] LAST_STEP = StepW'(GrayW - 1);

  logic [PixW-1:0]  rem_r, rem_nxt;
  logic [GrayW-1:0] sh_r, sh_nxt;
  logic [PixW-1:0]  den_r, den_nxt;
  logic [StepW-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [NumW-1:0]  num;
  logic [PixW:0]    trial;
  logic [PixW:0]    diff;
  logic             qbit;

  // Numerator d*255 as (d << 8) - d; its upper part is already below span
  assign num   = {offset, {GrayW{1'b0}}} - {{GrayW{1'b0}}, offset};
  assign trial = {rem_r, sh_r[GrayW-1]};
  assign diff  = trial - {1'b0, den_r};
  assign qbit  = (trial >= {1'b0, den_r});

  // Load on start, then shift one numerator bit in and one quotient bit out per cycle
  always_comb begin
    rem_nxt  = rem_r;
    sh_nxt   = sh_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = num[NumW-1:GrayW];
      sh_nxt   = num[GrayW-1:0];
      den_nxt  = span;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = qbit ? diff[PixW-1:0] : trial[PixW-1:0];
      sh_nxt  = {sh_r[GrayW-2:0], qbit};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == LAST_STEP) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    sh_r  <= sh_nxt;
    den_r <= den_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quot      = sh_r;

`ifndef SYNTHESIS
  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    !(start && busy_r))
    else $error("divider restarted while busy");
  a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (rem_r < den_r))
    else $error("partial remainder reached the divisor");
  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r)
    else $error("done held longer than one cycle");
`endif

endmodule

/* hw/rtl/mono16_contrast_stretch_to_gray8.sv */
// Top level: two-pass min/max contrast stretch of 16-bit samples to 8-bit gray.
// Measure requests are taken one per cycle while idle and give no result.
// Map requests with a value strictly inside the range go through the 8-step bit-serial
// divider; the next request is taken only once the result is in the output register.
// Map requests at or outside the range (or zero, or empty range) skip the divider.
// Reset (synchronous, active low) sets min to 65535, max to 0 and empties the output.
`timescale 1ns / 1ps

module mono16_contrast_stretch_to_gray8 (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] pixel
  input  logic [1:0]  in_tuser,   // [0] req_type, [1] frame_start
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata   // [7:0] gray
);
  import mcs_pkg::*;

  mcs_state_t       state_r, state_nxt;
  logic [PixW-1:0]  px_r, px_nxt;
  logic [PixW-1:0]  off_r, off_nxt;
  logic [PixW-1:0]  span_r, span_nxt;
  logic [GrayW-1:0] res_r, res_nxt;
  logic             out_vld_r, out_vld_nxt;
  logic [GrayW-1:0] out_dat_r, out_dat_nxt;
  logic             in_acc;
  logic             out_load;
  logic             div_start;
  mm_upd_t          mm_upd;
  div_stat_t        div_stat;
  logic [GrayW-1:0] div_quot;
  logic [PixW-1:0]  min_seen, max_seen;

  assign in_acc = in_tvalid && in_tready;

  // Measure requests go straight to the tracker
  assign mm_upd.en      = in_acc && (in_tuser[0] == REQ_MEASURE);
  assign mm_upd.restart = in_tuser[1];

  mcs_minmax u_minmax (
    .clk      (clk),
    .rst_n    (rst_n),
    .upd      (mm_upd),
    .pixel    (in_tdata),
    .min_seen (min_seen),
    .max_seen (max_seen)
  );

  mcs_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (div_start),
    .offset (off_r),
    .span   (span_r),
    .stat   (div_stat),
    .quot   (div_quot)
  );

  // Sequence map requests: classify, divide if needed, hand off to output register
  always_comb begin
    state_nxt = state_r;
    px_nxt    = px_r;
    off_nxt   = off_r;
    span_nxt  = span_r;
    res_nxt   = res_r;
    in_tready = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid && in_tuser[0] == REQ_MAP) begin
          px_nxt    = in_tdata;
          state_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        off_nxt  = px_r - min_seen;
        span_nxt = max_seen - min_seen;
        if (px_r == PIX_ZERO || min_seen >= max_seen || px_r <= min_seen) begin
          res_nxt   = GRAY_ZERO;
          state_nxt = ST_DONE;
        end else if (px_r >= max_seen) begin
          res_nxt   = GRAY_FULL;
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        div_start = !div_stat.busy && !div_stat.done;
        if (div_stat.done) begin
          res_nxt   = div_quot;
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_vld_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Output register: load a finished result, drop it once taken
  always_comb begin
    out_vld_nxt = out_vld_r;
    out_dat_nxt = out_dat_r;
    if (out_load) begin
      out_vld_nxt = 1'b1;
      out_dat_nxt = res_r;
    end else if (out_tready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    px_r      <= px_nxt;
    off_r     <= off_nxt;
    span_r    <= span_nxt;
    res_r     <= res_nxt;
    out_dat_r <= out_dat_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_dat_r;

`ifndef SYNTHESIS
  a_quot_inside: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV && div_stat.done) |-> (div_quot != GRAY_FULL))
    else $error("in-range pixel produced full-scale quotient");
  a_map_to_prep: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_tuser[0] == REQ_MAP) |=> (state_r == ST_PREP))
    else $error("accepted map request did not start processing");
  a_no_measure_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !mm_upd.en)
    else $error("min/max updated while a map request is in flight");
  a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (out_vld_r && out_dat_r == $past(res_r)))
    else $error("result lost on output load");
`endif

endmodule

/* tb/sv/mcs_stretch_checker.sv */
// Checker for the contrast stretch block: tracks min/max, predicts gray values, compares.
`timescale 1ns / 1ps

module mcs_stretch_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] pixel
  input  logic [1:0]  in_tuser,   // [0] req_type, [1] frame_start
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [7:0]  out_tdata,  // [7:0] gray
  output int          fail_count,
  output int          gray_pending
);
  import mcs_pkg::*;

  logic [PixW-1:0]  range_lo;
  logic [PixW-1:0]  range_hi;
  logic [GrayW-1:0] gray_expect[$];

  // Stretch one sample against the measured range
  function automatic logic [GrayW-1:0] stretch_gray(input logic [PixW-1:0] v,
                                                    input logic [PixW-1:0] lo,
                                                    input logic [PixW-1:0] hi);
    int unsigned q;
    if (v == PIX_ZERO || lo >= hi) return GRAY_ZERO;
    if (v <= lo) return GRAY_ZERO;
    if (v >= hi) return GRAY_FULL;
    q = ((int'(v) - int'(lo)) * int'(GRAY_FULL)) / (int'(hi) - int'(lo));
    if (q > int'(GRAY_FULL)) q = int'(GRAY_FULL);
    return q[GrayW-1:0];
  endfunction

  initial begin
    fail_count   = 0;
    gray_pending = 0;
  end

  always @(posedge clk) begin
    logic             req;
    logic             fs;
    logic [PixW-1:0]  pix;
    logic [PixW-1:0]  lo;
    logic [PixW-1:0]  hi;
    logic [GrayW-1:0] want;
    if (!rst_n) begin
      range_lo = PIX_MAX;
      range_hi = PIX_ZERO;
      gray_expect.delete();
    end else begin
      // Compare a delivered result with the oldest expectation
      if (out_tvalid && out_tready) begin
        if (gray_expect.size() == 0) begin
          $error("gray: expected none, actual %0d", out_tdata);
          fail_count++;
        end else begin
          want = gray_expect.pop_front();
          if (out_tdata !== want) begin
            $error("gray: expected %0d, actual %0d", want, out_tdata);
            fail_count++;
          end
        end
      end
      // Update the range on measure requests, predict on map requests
      if (in_tvalid && in_tready) begin
        req = in_tuser[0];
        fs  = in_tuser[1];
        pix = in_tdata;
        if (req == REQ_MEASURE) begin
          lo = fs ? PIX_MAX : range_lo;
          hi = fs ? PIX_ZERO : range_hi;
          if (pix != PIX_ZERO) begin
            if (pix < lo) lo = pix;
            if (pix > hi) hi = pix;
          end
          range_lo = lo;
          range_hi = hi;
        end else begin
          want        = stretch_gray(pix, range_lo, range_hi);
          gray_expect = {gray_expect, want};
        end
      end
    end
    gray_pending <= gray_expect.size();
  end

endmodule

/* tb/sv/tb_mono16_contrast_stretch_to_gray8.sv */
// Testbench top for the contrast stretch block: clock, reset, requests and verdict.
`timescale 1ns / 1ps

module tb_mono16_contrast_stretch_to_gray8;
  import mcs_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;   // [15:0] pixel
  logic [1:0]  in_tuser;   // [0] req_type, [1] frame_start
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;  // [7:0] gray
  int          fail_count;
  int          gray_pending;

  bit idle_en;
  bit long_hold_req;
  int req_sent;

  mono16_contrast_stretch_to_gray8 u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  mcs_stretch_checker u_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .fail_count   (fail_count),
    .gray_pending (gray_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Abort a hung run
  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  // Receiver: random stalls, plus one long hold-off on request
  initial begin
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (300) @(posedge clk);
        out_tready <= 1'b1;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Offer one request, hold it until taken, then maybe idle
  task automatic send_req(input logic req, input logic [15:0] pix, input logic fs);
    in_tvalid <= 1'b1;
    in_tdata  <= pix;
    in_tuser  <= {fs, req};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    req_sent++;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  // Draw a nonzero sample around base within span, zero now and then
  function automatic logic [15:0] frame_sample(input int base, input int span);
    int v;
    if ($urandom_range(0, 7) == 0) return PIX_ZERO;
    v = base + $urandom_range(0, span);
    if (v > 65535) v = 65535;
    return v[15:0];
  endfunction

  // Send measure/map frame pairs until about count requests went out
  task automatic run_frames(input int count);
    logic [15:0] frame_pix[16];
    int          stop_at;
    int          n;
    int          base;
    int          span;
    int          k;
    stop_at = req_sent + count;
    while (req_sent < stop_at) begin
      if ($urandom_range(0, 9) == 0) begin
        // Noise: arbitrary requests
        repeat ($urandom_range(1, 8))
          send_req(1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)),
                   1'($urandom_range(0, 1)));
      end else begin
        n    = $urandom_range(1, 16);
        base = $urandom_range(1, 65535);
        case ($urandom_range(0, 3))
          0: span = 0;
          1: span = $urandom_range(1, 255);
          2: span = $urandom_range(256, 4095);
          default: span = 65535;
        endcase
        if (span == 65535) base = $urandom_range(1, 16);
        for (k = 0; k < n; k++) frame_pix[k] = frame_sample(base, span);
        // Measure pass: frame start on the first pixel, rarely missing or repeated
        for (k = 0; k < n; k++)
          send_req(REQ_MEASURE, frame_pix[k],
                   (k == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 15) == 0));
        // Map pass over the same samples, with some arbitrary extras
        if ($urandom_range(0, 11) != 0) begin
          for (k = 0; k < n; k++)
            send_req(REQ_MAP, frame_pix[$urandom_range(0, n - 1)], $urandom_range(0, 7) == 0);
          if ($urandom_range(0, 3) == 0)
            send_req(REQ_MAP, 16'($urandom_range(0, 65535)), 1'b0);
        end
      end
    end
  endtask

  initial begin
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    in_tuser      = '0;
    idle_en       = 1'b1;
    long_hold_req = 1'b0;
    req_sent      = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Map before any measure: empty range
    send_req(REQ_MAP, 16'd1234, 1'b0);
    send_req(REQ_MAP, PIX_ZERO, 1'b0);
    // Full range, invalid pixel skipped
    send_req(REQ_MEASURE, 16'd100, 1'b1);
    send_req(REQ_MEASURE, PIX_ZERO, 1'b0);
    send_req(REQ_MEASURE, PIX_MAX, 1'b0);
    send_req(REQ_MEASURE, 16'd1, 1'b0);
    send_req(REQ_MAP, PIX_ZERO, 1'b0);
    send_req(REQ_MAP, 16'd1, 1'b0);
    send_req(REQ_MAP, PIX_MAX, 1'b0);
    send_req(REQ_MAP, 16'd32768, 1'b0);
    send_req(REQ_MAP, 16'd2, 1'b0);
    // Flat range
    send_req(REQ_MEASURE, 16'd500, 1'b1);
    send_req(REQ_MAP, 16'd500, 1'b0);
    send_req(REQ_MAP, 16'd600, 1'b0);
    // Restart, then frame start in map pass, below and above range
    send_req(REQ_MEASURE, 16'd1000, 1'b1);
    send_req(REQ_MEASURE, 16'd2000, 1'b0);
    send_req(REQ_MAP, 16'd1500, 1'b1);
    send_req(REQ_MAP, 16'd999, 1'b0);
    send_req(REQ_MAP, 16'd2001, 1'b0);
    send_req(REQ_MAP, 16'd1999, 1'b0);
    send_req(REQ_MEASURE, 16'd3000, 1'b0);
    send_req(REQ_MAP, 16'd2500, 1'b0);
    // Restart on an invalid pixel: empty range again
    send_req(REQ_MEASURE, PIX_ZERO, 1'b1);
    send_req(REQ_MAP, 16'd5, 1'b0);

    run_frames(400);

    // Pause until every result is back; the pending count is registered, so it lags the queue
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (gray_pending != 0) @(posedge clk);
    repeat (5) @(posedge clk);

    // Hold the receiver off while requests keep coming
    long_hold_req = 1'b1;
    send_req(REQ_MEASURE, 16'd40, 1'b1);
    send_req(REQ_MEASURE, 16'd60000, 1'b0);
    repeat (30) send_req(REQ_MAP, 16'($urandom_range(0, 65535)), 1'b0);

    run_frames(500);

    // Last stretch without idling
    idle_en = 1'b0;
    run_frames(100);

    // Drain and let the block settle
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (gray_pending != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (fail_count == 0 && gray_pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
